// ===== rtl/avg_pkg.sv =====
// Shared types and constants for the vector generator step unit.
package avg_pkg;

  localparam int MaxPoints  = 8192;
  localparam int CountW     = $clog2(MaxPoints + 1);
  localparam int StackDepth = 4;
  localparam int StackIdxW  = $clog2(StackDepth);
  localparam int PromDepth  = 256;
  localparam int PromAddrW  = 8;

  localparam logic [1:0] CmdStep  = 2'd0;
  localparam logic [1:0] CmdGo    = 2'd1;
  localparam logic [1:0] CmdReset = 2'd2;
  localparam logic [1:0] CmdLoad  = 2'd3;

  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegFlipX   = 2'd2;
  localparam logic [1:0] RegFlipY   = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StProm,
    StNorm,
    StScale,
    StMulA,
    StMulB,
    StDone
  } state_e;

  typedef struct packed {
    logic start;
    logic latch;
    logic strobe;
    logic norm_step;
    logic scale_step;
    logic mul_a;
    logic mul_b;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic is_step;
    logic do_strobe;
    logic need_norm;
    logic norm_busy;
    logic need_scale;
    logic scale_busy;
    logic need_move;
  } stat_t;

endpackage

// ===== rtl/avg_ram.sv =====
// Generic single-port write, registered-read RAM.
module avg_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/avg_ctrl.sv =====
// Sequencer state machine for one item.
module avg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  avg_pkg::stat_t stat_i,
  output avg_pkg::ctrl_t ctrl_o
);
  import avg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          state_d = stat_i.is_step ? StProm : StDone;
        end
      end
      StProm: begin
        ctrl_o.latch = 1'b1;
        if (!stat_i.do_strobe)      state_d = StDone;
        else if (stat_i.need_norm)  state_d = StNorm;
        else if (stat_i.need_scale) state_d = StScale;
        else if (stat_i.need_move)  state_d = StMulA;
        else begin
          ctrl_o.strobe = 1'b1;
          state_d = StDone;
        end
      end
      StNorm: begin
        if (stat_i.norm_busy) ctrl_o.norm_step = 1'b1;
        else begin
          ctrl_o.strobe = 1'b1;
          state_d = StDone;
        end
      end
      StScale: begin
        if (stat_i.scale_busy) ctrl_o.scale_step = 1'b1;
        else begin
          ctrl_o.strobe = 1'b1;
          state_d = StDone;
        end
      end
      StMulA: begin
        ctrl_o.mul_a = 1'b1;
        state_d = StMulB;
      end
      StMulB: begin
        ctrl_o.mul_b = 1'b1;
        ctrl_o.strobe = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctrl_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ===== rtl/avg_dp.sv =====
// Datapath: state PROM, latches, beam arithmetic and result registers.
module avg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  avg_pkg::ctrl_t      ctrl_i,
  output avg_pkg::stat_t      stat_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          bus_byte_i,
  input  logic [7:0]          prom_index_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output logic [15:0]         fetch_addr_o,
  output logic                halted_o,
  output logic                point_valid_o,
  output logic signed [31:0]  point_x_o,
  output logic signed [31:0]  point_y_o,
  output logic [3:0]          point_colour_o,
  output logic [7:0]          point_level_o
);
  import avg_pkg::*;

  logic [30:0] cx_q, cy_q;
  logic [9:0]  fx_q, fy_q;
  logic [1:0]  cmd_q;
  logic [7:0]  data_q;
  logic [4:0]  latch_q;
  logic [2:0]  op_q;
  logic [15:0] pc_q;
  logic [3:0]  sp_q;
  logic [15:0] stk_q [StackDepth];
  logic [12:0] dx_q, dy_q;
  logic        dyb_q;
  logic [14:0] tmr_q;
  logic [3:0]  il_q, col_q;
  logic [7:0]  ir_q, ls_q;
  logic [2:0]  bs_q, cnt_q;
  logic        halt_q;
  logic [31:0] bx_q, by_q;
  logic [CountW-1:0] pcount_q;
  logic signed [27:0] px_q, py_q;
  logic [7:0]  prom_rd;
  logic [7:0]  raddr;
  logic [3:0]  nl;
  logic [2:0]  hsel;

  avg_ram #(.Width(8), .Depth(PromDepth)) u_prom (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.start && cmd_i == CmdLoad),
    .waddr_i (prom_index_i),
    .wdata_i (bus_byte_i),
    .raddr_i (raddr),
    .rdata_o (prom_rd)
  );

  assign raddr = {~latch_q[4], op_q, latch_q[3:0]};
  assign nl    = prom_rd[3:0];
  assign hsel  = ctrl_i.latch ? nl[2:0] : latch_q[2:0];

  function automatic logic [14:0] tshift(logic [14:0] t, logic b);
    return (t >> 1) | 15'h4000 | {7'd0, b, 7'd0};
  endfunction

  logic norm_stop;
  assign norm_stop = (dy_q[12] ^ dy_q[11]) || (dx_q[12] ^ dx_q[11]);
  logic [4:0] ncnt_q;

  // move terms: v = ((d>>3)^flip) - 0x200 ; p = v * cycles ; q = p * (ls^ff)
  logic signed [10:0] vx, vy;
  logic [15:0] cyc;
  logic [7:0]  lsi;
  logic signed [27:0] mx, my;
  logic signed [43:0] qx, qy;
  assign vx  = $signed({1'b0, dx_q[12:3] ^ fx_q}) - 11'sd512;
  assign vy  = $signed({1'b0, dy_q[12:3] ^ fy_q}) - 11'sd512;
  assign cyc = op_q[1] ? (16'h100 - {8'd0, tmr_q[7:0]}) : (16'h8000 - {1'b0, tmr_q});
  assign lsi = ~ls_q;
  assign mx  = vx * $signed({1'b0, cyc});
  assign my  = vy * $signed({1'b0, cyc});
  assign qx  = px_q * $signed({1'b0, lsi});
  assign qy  = py_q * $signed({1'b0, lsi});

  logic [31:0] ax, ay;
  assign ax = 32'(qx >>> 4);
  assign ay = 32'(qy >>> 4);

  logic st;
  assign st = nl[3];
  assign stat_o.is_step    = cmd_i == CmdStep;
  assign stat_o.do_strobe  = st;
  assign stat_o.need_norm  = st && nl[2:0] == 3'd4 && !op_q[0];
  assign stat_o.norm_busy  = !norm_stop && ncnt_q != 5'd16;
  assign stat_o.need_scale = st && nl[2:0] == 3'd5 && !op_q[2];
  assign stat_o.scale_busy = cnt_q != 3'd0;
  assign stat_o.need_move  = st && nl[2:0] == 3'd7 && !op_q[0] && !op_q[2];

  logic full;
  assign full = pcount_q >= CountW'(MaxPoints);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= 31'h2000000; cy_q <= 31'h2000000; fx_q <= 10'h200; fy_q <= 10'h200;
      latch_q <= '0; op_q <= '0; pc_q <= '0; sp_q <= '0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= '0;
      dx_q <= '0; dy_q <= '0; dyb_q <= 1'b0; tmr_q <= '0;
      il_q <= '0; ir_q <= '0; col_q <= '0; ls_q <= '0; bs_q <= '0;
      halt_q <= 1'b1; bx_q <= 32'h2000000; by_q <= 32'h2000000; pcount_q <= '0;
      point_valid_o <= 1'b0; point_x_o <= '0; point_y_o <= '0;
      point_colour_o <= '0; point_level_o <= '0;
      cmd_q <= '0; data_q <= '0; cnt_q <= '0; ncnt_q <= '0; px_q <= '0; py_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCenterX: cx_q <= cfg_data_i[30:0];
          RegCenterY: cy_q <= cfg_data_i[30:0];
          RegFlipX:   fx_q <= cfg_data_i[9:0];
          RegFlipY:   fy_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (ctrl_i.start) begin
        cmd_q <= cmd_i; data_q <= bus_byte_i;
        point_valid_o <= 1'b0; point_x_o <= '0; point_y_o <= '0;
        point_colour_o <= '0; point_level_o <= '0;
        unique case (cmd_i)
          CmdGo: begin
            pc_q <= '0; sp_q <= '0; pcount_q <= '0; halt_q <= 1'b0;
          end
          CmdReset: begin
            latch_q <= '0; bs_q <= '0; ls_q <= '0; col_q <= '0; halt_q <= 1'b1;
          end
          default: ;
        endcase
      end
      if (ctrl_i.latch) begin
        latch_q[3:0] <= nl;
        cnt_q  <= bs_q;
        ncnt_q <= '0;
      end
      if (ctrl_i.norm_step) begin
        dy_q   <= {dy_q[12], dy_q[10:0], 1'b0};
        dx_q   <= {dx_q[12], dx_q[10:0], 1'b0};
        tmr_q  <= tshift(tmr_q, op_q[1]);
        ncnt_q <= ncnt_q + 5'd1;
      end
      if (ctrl_i.scale_step) begin
        tmr_q <= tshift(tmr_q, op_q[1]);
        cnt_q <= cnt_q - 3'd1;
      end
      if (ctrl_i.mul_a) begin
        px_q <= mx; py_q <= my;
      end
      if (ctrl_i.strobe) begin
        unique case (hsel)
          3'd0: begin
            dy_q[7:0] <= data_q; pc_q <= pc_q + 16'd1;
          end
          3'd1: begin
            dyb_q <= data_q[4]; op_q <= data_q[7:5]; il_q <= '0;
            dy_q <= {data_q[4], data_q[3:0], 8'd0}; dx_q <= '0; pc_q <= pc_q + 16'd1;
          end
          3'd2: begin
            dx_q[7:0] <= data_q; pc_q <= pc_q + 16'd1;
          end
          3'd3: begin
            il_q <= data_q[7:4];
            dx_q[12:8] <= {data_q[4], data_q[3:0]}; pc_q <= pc_q + 16'd1;
          end
          3'd4: begin
            if (op_q[0]) stk_q[sp_q[StackIdxW-1:0]] <= pc_q;
            else if (op_q[1]) tmr_q[14:8] <= '0;
          end
          3'd5: begin
            if (!op_q[2]) begin
              if (op_q[1]) tmr_q[14:8] <= '0;
            end else sp_q <= op_q[1] ? sp_q - 4'd1 : sp_q + 4'd1;
          end
          3'd6: begin
            if (!op_q[2] && !dyb_q) begin
              ir_q <= dy_q[7:0]; col_q <= dy_q[11:8];
            end
            if (op_q[2]) begin
              if (op_q[0]) begin
                pc_q <= {2'b00, dy_q, 1'b0};
                if (dy_q == '0 && pcount_q > CountW'(10)) halt_q <= 1'b1;
              end else pc_q <= stk_q[sp_q[StackIdxW-1:0]];
            end else if (dyb_q) begin
              ls_q <= dy_q[7:0]; bs_q <= dy_q[10:8];
            end
          end
          default: begin
            halt_q <= op_q[0];
            if (!op_q[0] && !op_q[2]) begin
              tmr_q <= '0;
              bx_q <= bx_q + ax;
              by_q <= by_q - ay;
              if (!full) begin
                pcount_q <= pcount_q + CountW'(1);
                point_valid_o <= 1'b1;
                point_x_o <= bx_q + ax; point_y_o <= by_q - ay;
                point_colour_o <= col_q;
                point_level_o <= 8'((12'({1'b0, il_q[3:1]}) * 12'(ir_q)) >> 3);
              end
            end
            if (op_q[2]) begin
              tmr_q <= '0; bx_q <= {1'b0, cx_q}; by_q <= {1'b0, cy_q};
              if (!full) begin
                pcount_q <= pcount_q + CountW'(1);
                point_valid_o <= 1'b1;
                point_x_o <= {1'b0, cx_q}; point_y_o <= {1'b0, cy_q};
                point_colour_o <= '0; point_level_o <= '0;
              end
            end
          end
        endcase
      end
      if (ctrl_i.finish && cmd_q == CmdStep) latch_q[4] <= halt_q;
    end
  end

  assign fetch_addr_o = pc_q;
  assign halted_o     = halt_q;
endmodule

// ===== rtl/analog_vector_generator_step_unit.sv =====
// Top level of the vector generator step unit.
// Item paths: load, go and reset go straight to the result; a step reads the
// state PROM, a normalizing step then shifts up to 16 times, a timer scaling step
// shifts up to 7 times, and a beam move step passes the two multiply stages.
// One item at a time; the result is held until taken, then the next beat is taken.
// Reset: registers to their home values, halted; the state PROM is not cleared.
module analog_vector_generator_step_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         bus_byte_i,
  input  logic [7:0]         prom_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        fetch_addr_o,
  output logic               halted_o,
  output logic               point_valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [3:0]         point_colour_o,
  output logic [7:0]         point_level_o
);
  import avg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  avg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i (stat), .ctrl_o (ctrl)
  );

  avg_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i (ctrl), .stat_o (stat),
    .cmd_i, .bus_byte_i, .prom_index_i,
    .cfg_we_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_data_i,
    .fetch_addr_o, .halted_o, .point_valid_o, .point_x_o, .point_y_o,
    .point_colour_o, .point_level_o
  );
endmodule

// ===== rtl/avg_checker.sv =====
// Port-level assertions for the vector generator step unit.
module avg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       point_valid_o,
  input logic [7:0] point_level_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second beat accepted early");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> point_level_o == 8'd0) else $error("stray level");
endmodule

bind analog_vector_generator_step_unit avg_checker u_avg_checker (.*);
